[rtl/core/idsc_pkg.sv]
package idsc_pkg;

    localparam int BITMAP_WORDS = 16384;
    localparam int MAX_REPORTS  = 64;

    localparam int WORD_AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int NREP_W  = $clog2(MAX_REPORTS + 1);

    localparam int SPP_W   = 7;
    localparam int IVL_W   = 40;
    localparam int PAGE_W  = 32;
    localparam int OFS_W   = 6;
    localparam int NOW_W   = 63;
    localparam int DIST_W  = 21;
    localparam int REQ_W   = 32;
    localparam int BND_W   = 64;
    localparam int MAP_W   = 64;
    localparam int BITPOS_W = 6;
    // page * spp + offset, exact
    localparam int BIT_W   = PAGE_W + SPP_W + 1;
    localparam int WIDX_W  = BIT_W - BITPOS_W;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = IVL_W;

    localparam logic [SPP_W-1:0] SPP_RESET = SPP_W'(8);
    localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(1000000000);

    typedef enum logic [1:0] {
        CMD_COUNT   = 2'd0,
        CMD_MARK    = 2'd1,
        CMD_TIME    = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPP = 1'b0,
        REG_IVL = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MARK_WR,
        S_REPORT,
        S_CLEAR
    } t_state;

    typedef struct packed {
        t_cmd                cmd;
        logic [PAGE_W-1:0]   page;
        logic [OFS_W-1:0]    offset;
        logic [NOW_W-1:0]    now;
    } t_item;

    typedef struct packed {
        logic                last;
        logic [REQ_W-1:0]    request;
        logic [DIST_W-1:0]   distinct;
    } t_report;

endpackage

[rtl/core/idsc_ram.sv]
module idsc_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/idsc_engine.sv]
module idsc_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [idsc_pkg::SPP_W-1:0] i_spp,
    input  logic [idsc_pkg::IVL_W-1:0] i_interval,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  idsc_pkg::t_item            i_item,
    output logic                       o_rep_valid,
    input  logic                       i_rep_ready,
    output idsc_pkg::t_report          o_rep
);

    import idsc_pkg::*;

    t_state r_state, n_state;

    logic [DIST_W-1:0]   r_distinct;
    logic [REQ_W-1:0]    r_request;
    logic [BND_W-1:0]    r_boundary;
    logic [NOW_W-1:0]    r_now;
    logic [NREP_W-1:0]   r_nrep;
    logic                r_dirty;
    logic [WORD_AW-1:0]  r_clr_addr;
    logic [WORD_AW-1:0]  r_mk_addr;
    logic [BITPOS_W-1:0] r_mk_bit;
    logic                r_mk_hit;

    logic [BIT_W-1:0]    w_bit;
    logic [WIDX_W-1:0]   w_word;
    logic                w_in_range;
    logic                w_fire;
    logic                w_due;
    logic                w_more;
    logic                w_last;
    logic [BND_W-1:0]    w_bnext;
    logic                w_rep_fire;
    logic                w_bit_clear;
    logic                w_clr_done;

    logic                ram_we;
    logic [WORD_AW-1:0]  ram_waddr;
    logic [MAP_W-1:0]    ram_wdata;
    logic [MAP_W-1:0]    ram_rdata;
    logic [MAP_W-1:0]    w_mask;

    // bitmap index straight from the incoming transfer so the read goes out at accept
    assign w_bit      = BIT_W'(i_item.page) * BIT_W'(i_spp) + BIT_W'(i_item.offset);
    assign w_word     = w_bit[BIT_W-1:BITPOS_W];
    assign w_in_range = w_word < WIDX_W'(BITMAP_WORDS);
    assign w_fire     = i_valid && o_ready;

    assign w_mask      = MAP_W'(1) << r_mk_bit;
    assign w_bit_clear = (ram_rdata & w_mask) == '0;

    assign w_due      = r_boundary < BND_W'(r_now);
    assign w_bnext    = r_boundary + BND_W'(i_interval);
    assign w_more     = w_bnext < BND_W'(r_now);
    assign w_last     = !w_more || (r_nrep == NREP_W'(MAX_REPORTS - 1));
    assign w_rep_fire = o_rep_valid && i_rep_ready;
    assign w_clr_done = r_clr_addr == WORD_AW'(BITMAP_WORDS - 1);

    assign o_rep.last     = w_last;
    assign o_rep.request  = r_request;
    assign o_rep.distinct = r_distinct;

    idsc_ram #(
        .DEPTH (BITMAP_WORDS),
        .WIDTH (MAP_W),
        .AW    (WORD_AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (w_word[WORD_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    unique case (i_item.cmd)
                        CMD_COUNT:   n_state = S_IDLE;
                        CMD_MARK:    n_state = S_MARK_WR;
                        CMD_TIME:    n_state = S_REPORT;
                        CMD_RESTART: n_state = r_dirty ? S_CLEAR : S_IDLE;
                    endcase
                end
            end
            S_MARK_WR: begin
                n_state = S_IDLE;
            end
            S_REPORT: begin
                if (!w_due) begin
                    n_state = S_IDLE;
                end else if (w_rep_fire && w_last) begin
                    n_state = r_dirty ? S_CLEAR : S_IDLE;
                end
            end
            S_CLEAR: begin
                if (w_clr_done) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ready     = 1'b0;
        o_rep_valid = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_mk_addr;
        ram_wdata   = ram_rdata | w_mask;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_MARK_WR: begin
                ram_we = r_mk_hit && w_bit_clear;
            end
            S_REPORT: begin
                o_rep_valid = w_due;
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_distinct <= '0;
            r_request  <= '0;
            r_boundary <= BND_W'(IVL_RESET);
            r_nrep     <= '0;
            r_dirty    <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (w_fire) begin
                        unique case (i_item.cmd)
                            CMD_COUNT: begin
                                if (r_request != '1) begin
                                    r_request <= r_request + REQ_W'(1);
                                end
                            end
                            CMD_MARK: begin
                            end
                            CMD_TIME: begin
                                r_nrep <= '0;
                            end
                            CMD_RESTART: begin
                                r_boundary <= BND_W'(i_item.now) + BND_W'(i_interval);
                                r_distinct <= '0;
                                r_request  <= '0;
                            end
                        endcase
                    end
                end
                S_MARK_WR: begin
                    if (ram_we) begin
                        r_dirty <= 1'b1;
                        if (r_distinct != '1) begin
                            r_distinct <= r_distinct + DIST_W'(1);
                        end
                    end
                end
                S_REPORT: begin
                    if (w_rep_fire) begin
                        r_distinct <= '0;
                        r_request  <= '0;
                        r_boundary <= w_bnext;
                        r_nrep     <= r_nrep + NREP_W'(1);
                    end
                end
                S_CLEAR: begin
                    if (w_clr_done) begin
                        r_clr_addr <= '0;
                        r_dirty    <= 1'b0;
                    end else begin
                        r_clr_addr <= r_clr_addr + WORD_AW'(1);
                    end
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_now     <= i_item.now;
            r_mk_addr <= w_word[WORD_AW-1:0];
            r_mk_bit  <= w_bit[BITPOS_W-1:0];
            r_mk_hit  <= w_in_range;
        end
    end

endmodule

[rtl/core/interval_distinct_sector_counter.sv]
// Count transfer: counted at accept. Mark transfer: bitmap RAM read at accept, then write-back.
// Restart transfer: boundary and counts set at accept. Time transfer: if nothing is due, back to
// idle with no report; else reports go out while the output is taken, up to 64; a report register
// parts input and output. After a time transfer that reported, or a restart, a bitmap that was
// marked is swept clear at one word a cycle, input stalled. Reset: synchronous, active low; counts
// zero, boundary 1000000000, then the same sweep.
module interval_distinct_sector_counter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [idsc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [idsc_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [103:0]                     s_tdata,  // page_address, sector_offset, now, pad
    input  logic [1:0]                       s_tuser,  // command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [55:0]                      m_tdata,  // distinct_sectors, request_total, pad
    output logic                             m_tlast   // last_report
);

    import idsc_pkg::*;

    logic [SPP_W-1:0] r_spp;
    logic [IVL_W-1:0] r_interval;
    logic             r_out_valid;
    t_report          r_out;

    t_item            item;
    logic             rep_valid;
    logic             rep_ready;
    logic             rep_fire;
    t_report          rep;

    assign item.cmd    = t_cmd'(s_tuser);
    assign item.page   = s_tdata[31:0];
    assign item.offset = s_tdata[37:32];
    assign item.now    = s_tdata[100:38];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spp      <= SPP_RESET;
            r_interval <= IVL_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_SPP: r_spp      <= i_cfg_wdata[SPP_W-1:0];
                REG_IVL: r_interval <= i_cfg_wdata[IVL_W-1:0];
            endcase
        end
    end

    idsc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_spp       (r_spp),
        .i_interval  (r_interval),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_item      (item),
        .o_rep_valid (rep_valid),
        .i_rep_ready (rep_ready),
        .o_rep       (rep)
    );

    assign rep_ready = !r_out_valid || m_tready;
    assign rep_fire  = rep_valid && rep_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rep_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rep_fire) begin
            r_out <= rep;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {3'b000, r_out.request, r_out.distinct};
    assign m_tlast  = r_out.last;

    // a final report ends the run: nothing more until the next time transfer
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rep_fire && rep.last) |=> !rep_valid)
        else $error("report offered after final report");

    // only the first report of a run can carry counts
    a_later_reports_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rep_fire && !rep.last) |=> (!rep_valid || (rep.distinct == '0 && rep.request == '0)))
        else $error("nonzero counts on a later report");

    // a restart never produces a report
    a_restart_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && s_tuser == CMD_RESTART) |=> !rep_valid)
        else $error("report after restart");

    // the report register is never overwritten while it still holds a result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_tready && rep_valid) |=> (r_out_valid && $stable(r_out)))
        else $error("pending report overwritten");

endmodule

[dv/tb_interval_distinct_sector_counter.sv]
`timescale 1ns / 100ps

module tb_interval_distinct_sector_counter;
    import idsc_pkg::*;

    localparam logic [NOW_W-1:0] NOW_MAX  = {NOW_W{1'b1}};
    localparam logic [63:0]      MAP_BITS = 64'(BITMAP_WORDS) * 64;
    localparam logic [NOW_W-1:0] ONE_SEC  = NOW_W'(1000000000);
    localparam int RAND_ITEMS  = 40;
    localparam int N_SETTINGS  = 5;
    localparam int DRAIN_LIMIT = 4000000;

    typedef struct {
        t_item   it;
        int      n_typed;   // -1: left to the predictor, else 0 or 1 typed report
        t_report rep;
    } t_dir_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [103:0]         s_tdata     = '0;  // page_address, sector_offset, now, pad
    logic [1:0]           s_tuser     = '0;  // command
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [55:0]          m_tdata;           // distinct_sectors, request_total, pad
    logic                 m_tlast;

    interval_distinct_sector_counter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // shadow of the block's state
    logic [SPP_W-1:0]  spp_q;
    logic [IVL_W-1:0]  ivl_q;
    logic [BND_W-1:0]  bnd_q;
    logic [DIST_W-1:0] dist_q;
    logic [REQ_W-1:0]  req_q;
    logic [MAP_W-1:0]  sector_map [int unsigned];

    t_report  pending_reports [$];
    t_dir_row dir_rows [$];

    int n_err        = 0;
    int items_sent   = 0;
    int reports_seen = 0;
    bit hold_req     = 1'b0;
    bit tx_burst     = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #60000000;
        $display("tb_interval_distinct_sector_counter: errors");
        $finish;
    end

    task automatic clear_interval_model();
        sector_map.delete();
        dist_q = '0;
        req_q  = '0;
    endtask

    // updates the shadow state and, unless quiet, queues the reports one transfer causes
    task automatic predict_reports(input t_item it, input bit quiet);
        logic [63:0]      bidx;
        int unsigned      widx;
        logic [MAP_W-1:0] w;
        t_report          rq [$];
        t_report          r;
        case (it.cmd)
            CMD_COUNT: begin
                if (req_q != '1) req_q = req_q + 1'b1;
            end
            CMD_MARK: begin
                bidx = 64'(it.page) * 64'(spp_q) + 64'(it.offset);
                if (bidx < MAP_BITS) begin
                    widx = 32'(bidx >> 6);
                    w = sector_map.exists(widx) ? sector_map[widx] : '0;
                    if (!w[bidx[5:0]]) begin
                        w[bidx[5:0]] = 1'b1;
                        sector_map[widx] = w;
                        if (dist_q != '1) dist_q = dist_q + 1'b1;
                    end
                end
            end
            CMD_TIME: begin
                while (bnd_q < 64'(it.now) && rq.size() < MAX_REPORTS) begin
                    r.distinct = dist_q;
                    r.request  = req_q;
                    r.last     = 1'b0;
                    rq.push_back(r);
                    clear_interval_model();
                    bnd_q = bnd_q + 64'(ivl_q);
                end
                if (rq.size() > 0) rq[rq.size()-1].last = 1'b1;
            end
            CMD_RESTART: begin
                bnd_q = 64'(it.now) + 64'(ivl_q);
                clear_interval_model();
            end
        endcase
        if (!quiet) begin
            foreach (rq[k]) pending_reports.push_back(rq[k]);
        end
    endtask

    task automatic send_item(input t_item it, input int n_typed, input t_report rep);
        int gap;
        if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {3'b000, it.now, it.offset, it.page};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
        predict_reports(it, n_typed >= 0);
        if (n_typed == 1) pending_reports.push_back(rep);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_SPP) spp_q = val[SPP_W-1:0];
        else ivl_q = val[IVL_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input t_cmd c, input logic [PAGE_W-1:0] pg,
                           input logic [OFS_W-1:0] ofs, input logic [NOW_W-1:0] tnow,
                           input int n, input logic [DIST_W-1:0] d,
                           input logic [REQ_W-1:0] q);
        t_dir_row row;
        row.it.cmd       = c;
        row.it.page      = pg;
        row.it.offset    = ofs;
        row.it.now       = tnow;
        row.n_typed      = n;
        row.rep.distinct = d;
        row.rep.request  = q;
        row.rep.last     = 1'b1;
        dir_rows.push_back(row);
    endtask

    // mostly marks and counts ahead of time steps that mostly land past the boundary
    function automatic t_item rand_item();
        t_item       it;
        int unsigned r;
        logic [63:0] t;
        logic [63:0] span;
        logic [63:0] page_lim;
        r         = $urandom_range(0, 99);
        it.page   = $urandom;
        it.offset = $urandom_range(0, 63);
        it.now    = NOW_W'({$urandom, $urandom});
        if (r < 35) begin
            it.cmd = CMD_COUNT;
        end else if (r < 70) begin
            it.cmd = CMD_MARK;
            page_lim = (spp_q == 0) ? 64'hFFFF_FFFF : MAP_BITS / 64'(spp_q);
            case ($urandom_range(0, 9))
                0: ;  // anywhere, mostly off the end of the map
                1, 2, 3: it.page = $urandom_range(0, 7);
                default: it.page = PAGE_W'({$urandom, $urandom} % page_lim);
            endcase
        end else if (r < 90) begin
            it.cmd = CMD_TIME;
            case ($urandom_range(0, 9))
                0, 1: t = (bnd_q > 3) ? bnd_q - 64'($urandom_range(0, 3)) : 64'd0;
                2: t = 64'(it.now);
                default: begin
                    span = 3 * 64'(ivl_q) + 1;
                    t = bnd_q + 1 + ({$urandom, $urandom} % span);
                end
            endcase
            it.now = (t > 64'(NOW_MAX)) ? NOW_MAX : t[NOW_W-1:0];
        end else begin
            it.cmd = CMD_RESTART;
            if ($urandom_range(0, 4) != 0) it.now = NOW_W'($urandom);
        end
        return it;
    endfunction

    task automatic flag(input string field, input logic [63:0] want, input logic [63:0] seen);
        n_err++;
        if (n_err <= 40)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, seen);
    endtask

    // report side: random stalls, plus one long hold-off on request
    initial begin
        int      stall_left;
        bit      rx_burst;
        t_report want;
        t_report got;
        stall_left = 0;
        rx_burst   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready) begin
                got.distinct = m_tdata[DIST_W-1:0];
                got.request  = m_tdata[DIST_W+REQ_W-1:DIST_W];
                got.last     = m_tlast;
                reports_seen++;
                if (pending_reports.size() == 0) begin
                    n_err++;
                    if (n_err <= 40)
                        $display("%0t: unexpected report: expected none, got %0d/%0d/%0b",
                                 $time, got.distinct, got.request, got.last);
                end else begin
                    want = pending_reports.pop_front();
                    if (got.distinct !== want.distinct)
                        flag("distinct_sectors", want.distinct, got.distinct);
                    if (got.request !== want.request)
                        flag("request_total", want.request, got.request);
                    if (got.last !== want.last)
                        flag("last_report", want.last, got.last);
                end
                if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
                stall_left = rx_burst ? 0 : $urandom_range(0, 9);
            end
            if (hold_req) begin
                stall_left = 400;
                hold_req   = 1'b0;
            end
            m_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    initial begin
        t_item            it;
        t_report          no_rep;
        logic [SPP_W-1:0] spp_w;
        logic [IVL_W-1:0] ivl_w;
        int               n_dir;
        int               k;
        no_rep = '0;
        spp_q  = SPP_RESET;
        ivl_q  = IVL_RESET;
        bnd_q  = 64'(IVL_RESET);
        clear_interval_model();

        add_row(CMD_TIME,    0,            0,  0,               0, 0, 0);
        add_row(CMD_TIME,    0,            0,  ONE_SEC,         0, 0, 0);  // on the boundary
        add_row(CMD_COUNT,   32'hFFFF_FFFF, 63, NOW_MAX,        -1, 0, 0);
        add_row(CMD_COUNT,   0,            0,  0,              -1, 0, 0);
        add_row(CMD_MARK,    0,            0,  0,              -1, 0, 0);
        add_row(CMD_MARK,    0,            0,  0,              -1, 0, 0);  // repeat sector
        add_row(CMD_MARK,    0,            63, 0,              -1, 0, 0);
        add_row(CMD_MARK,    131071,       7,  0,              -1, 0, 0);  // last map bit
        add_row(CMD_MARK,    131072,       0,  0,              -1, 0, 0);  // just off the map
        add_row(CMD_MARK,    32'hFFFF_FFFF, 63, NOW_MAX,       -1, 0, 0);
        add_row(CMD_TIME,    0,            0,  ONE_SEC + 1,     1, 3, 2);
        add_row(CMD_COUNT,   0,            0,  0,              -1, 0, 0);
        add_row(CMD_TIME,    0,            0,  4 * ONE_SEC + 1, -1, 0, 0);
        add_row(CMD_RESTART, 0,            0,  NOW_MAX,        -1, 0, 0);
        add_row(CMD_TIME,    32'hFFFF_FFFF, 63, NOW_MAX,        0, 0, 0);
        add_row(CMD_RESTART, 0,            0,  0,              -1, 0, 0);
        add_row(CMD_MARK,    5,            3,  0,              -1, 0, 0);
        add_row(CMD_COUNT,   0,            0,  0,              -1, 0, 0);
        add_row(CMD_TIME,    0,            0,  NOW_MAX,        -1, 0, 0);  // report cap
        add_row(CMD_TIME,    0,            0,  NOW_MAX,        -1, 0, 0);  // still pending
        add_row(CMD_RESTART, 0,            0,  100,            -1, 0, 0);
        add_row(CMD_TIME,    0,            0,  ONE_SEC + 101,   1, 0, 0);
        n_dir = dir_rows.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].n_typed, dir_rows[k].rep);

        for (int ph = 0; ph < N_SETTINGS; ph++) begin
            // let any bitmap sweep finish before touching the registers
            wait_drained();
            repeat (BITMAP_WORDS + 64) @(posedge i_clk);
            case (ph)
                0: begin spp_w = 1;   ivl_w = 1000;                      end
                1: begin spp_w = 64;  ivl_w = 1;                         end
                2: begin spp_w = 0;   ivl_w = 0;                         end
                3: begin spp_w = 127; ivl_w = '1;                        end
                default: begin spp_w = 13; ivl_w = $urandom_range(1, 5000); end
            endcase
            write_reg(REG_SPP, CFG_W'(spp_w));
            write_reg(REG_IVL, CFG_W'(ivl_w));
            for (k = 0; k < RAND_ITEMS; k++) begin
                if (ph == 1 && k == 10) begin
                    // long output hold while a burst of reports backs up the input
                    hold_req  = 1'b1;
                    it        = rand_item();
                    it.cmd    = CMD_TIME;
                    it.now    = NOW_W'(bnd_q + 40);
                end else begin
                    if (ph == 1 && k == 25) wait_drained();
                    it = rand_item();
                end
                send_item(it, -1, no_rep);
            end
        end

        s_tvalid <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && pending_reports.size() != 0; k++) @(posedge i_clk);
        repeat (BITMAP_WORDS + 200) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            n_err++;
            $display("%0t: %0d reports still expected, none arrived", $time,
                     pending_reports.size());
        end

        $display("Ran %0d transfers in (%0d directed), %0d reports checked, %0d mismatches",
                 items_sent, n_dir, reports_seen, n_err);
        $display("Settings: reset values, zero and oversized page size, zero and full interval");
        if (n_err == 0) begin
            $display("tb_interval_distinct_sector_counter: clean");
        end else begin
            $display("tb_interval_distinct_sector_counter: errors");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/idsc_pkg.sv
rtl/core/idsc_ram.sv
rtl/core/idsc_engine.sv
rtl/core/interval_distinct_sector_counter.sv
dv/tb_interval_distinct_sector_counter.sv
